/* rtl/prba_pkg.sv */
// Shared types and constants for the page run bitmap allocator.
package prba_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned WORD_LSB  = 5;

  localparam logic        REG_HEAP_BASE  = 1'b0;
  localparam logic        REG_PAGE_COUNT = 1'b1;
  localparam logic [10:0] PAGE_COUNT_RST = 11'd1024;

  typedef struct packed {
    logic load;
    logic scan;
    logic wr_cur;
    logic wr_prev;
  } dp_cmd_t;

  typedef struct packed {
    logic bad_len;
    logic found;
    logic last_word;
  } dp_status_t;

endpackage

/* rtl/prba_ctrl.sv */
// Controller state machine for the page run bitmap allocator.
module prba_ctrl
  import prba_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy,
  output logic       done
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_SCAN    = 5'b00010,
    S_WR_CUR  = 5'b00100,
    S_WR_PREV = 5'b01000,
    S_RESULT  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = status.bad_len ? S_RESULT : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.found) begin
          state_next = S_WR_CUR;
        end else if (status.last_word) begin
          state_next = S_RESULT;
        end
      end
      S_WR_CUR: begin
        cmd.wr_cur = 1'b1;
        state_next = S_WR_PREV;
      end
      S_WR_PREV: begin
        cmd.wr_prev = 1'b1;
        state_next  = S_RESULT;
      end
      S_RESULT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_RESULT);

endmodule

/* rtl/prba_dp.sv */
// Datapath: config registers, free-page bitmap memory, run search and address.
module prba_dp
  import prba_pkg::*;
#(
  parameter int unsigned NUM_PAGES  = 1024,
  parameter int unsigned MAX_RUN    = 16,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  input  logic [4:0]  request_pages,
  input  logic        cfg_valid,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output logic [31:0] addr_q,
  output logic        grant_q
);

  localparam int unsigned NUM_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned LW        = $clog2(NUM_PAGES + 1);

  logic [31:0]   heap_base;
  logic [10:0]   page_count;
  logic [LW-1:0] limit;

  logic [5:0]    len_q;
  logic [WW-1:0] scan_w;
  logic [31:0]   prev_masked;
  logic [31:0]   prev_raw;
  logic [31:0]   cur_raw_q;
  logic [4:0]    hit_j;

  logic [31:0]   mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] valid;
  logic [31:0]   rdata;
  logic          rvalid;
  logic [WW-1:0] raddr;
  logic [WW-1:0] waddr;
  logic [31:0]   wdata;
  logic          we;

  logic [31:0]   eff;
  logic [31:0]   lim_mask;
  logic [31:0]   cur_masked;
  logic [31:0]   winmask;
  logic [63:0]   ext;
  logic [31:0]   ok;
  logic [4:0]    first_j;
  logic [63:0]   cm;
  logic [31:0]   start_page;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= '0;
      page_count <= PAGE_COUNT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HEAP_BASE:  heap_base  <= cfg_data;
        REG_PAGE_COUNT: page_count <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  assign limit = (32'(page_count) > NUM_PAGES) ? LW'(NUM_PAGES) : LW'(page_count);

  assign status.bad_len = (request_pages == 5'd0) || (32'(request_pages) > MAX_RUN) ||
                          (32'(request_pages) > 32'(limit));

  // bitmap memory, unwritten words read as all free
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rvalid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      rvalid <= valid[raddr];
    end
  end

  assign eff = rvalid ? rdata : '1;

  always_comb begin
    if (32'(scan_w) < 32'(limit >> WORD_LSB)) begin
      lim_mask = '1;
    end else if (32'(scan_w) == 32'(limit >> WORD_LSB)) begin
      lim_mask = ~(32'hFFFF_FFFF << limit[4:0]);
    end else begin
      lim_mask = '0;
    end
  end

  assign cur_masked = eff & lim_mask;
  assign winmask    = ~(32'hFFFF_FFFF >> len_q);
  assign ext        = {cur_masked, prev_masked};

  // ok[j]: a run of len_q free pages ends at bit j of the current word
  always_comb begin
    for (int j = 0; j < 32; j++) begin
      ok[j] = &(ext[j+32 -: 32] | ~winmask);
    end
  end

  always_comb begin
    first_j = '0;
    for (int j = 31; j >= 0; j--) begin
      if (ok[j]) begin
        first_j = 5'(j);
      end
    end
  end

  assign status.found     = |ok;
  assign status.last_word = (32'(scan_w) == NUM_WORDS - 1);

  always_comb begin
    if (cmd.load) begin
      raddr = '0;
    end else if (status.last_word) begin
      raddr = scan_w;
    end else begin
      raddr = WW'(scan_w + 1'b1);
    end
  end

  assign cm = {32'b0, winmask} << (6'(hit_j) + 6'd1);

  always_comb begin
    we    = 1'b0;
    waddr = scan_w;
    wdata = cur_raw_q & ~cm[63:32];
    if (cmd.wr_cur) begin
      we = 1'b1;
    end else if (cmd.wr_prev) begin
      we    = (scan_w != '0);
      waddr = WW'(scan_w - 1'b1);
      wdata = prev_raw & ~cm[31:0];
    end
  end

  assign start_page = (32'(scan_w) << WORD_LSB) + 32'(hit_j) + 32'd1 - 32'(len_q);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      len_q       <= 6'(request_pages);
      scan_w      <= '0;
      prev_masked <= '0;
      prev_raw    <= '0;
    end else if (cmd.scan) begin
      if (status.found) begin
        hit_j     <= first_j;
        cur_raw_q <= eff;
      end else begin
        scan_w      <= WW'(scan_w + 1'b1);
        prev_masked <= cur_masked;
        prev_raw    <= eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grant_q <= 1'b0;
      addr_q  <= '0;
    end else if (cmd.load) begin
      grant_q <= 1'b0;
      addr_q  <= '0;
    end else if (cmd.wr_cur) begin
      grant_q <= 1'b1;
      addr_q  <= heap_base + (start_page << PAGE_SHIFT);
    end
  end

endmodule

/* rtl/page_run_bitmap_allocator.sv */
// Top level of the page run bitmap allocator.
// First-fit allocator of runs of 1 to MAX_RUN contiguous pages out of a bitmap of
// NUM_PAGES free bits held as 32-bit words in an on-chip memory; all pages are free
// after reset and are only freed again by reset. A request is taken when start is
// high and busy is low; exactly one result follows, shown for one cycle with done
// high, and must be taken in that cycle since the block cannot hold it. A rejected
// request (zero length, above MAX_RUN, or longer than the page count) shows its
// result in the cycle right after acceptance. A search reads one bitmap word per
// cycle through the single memory read port; a grant then updates, through the
// single write port, the word where the run ends and then the one before it, if
// any. The next request can be taken in the cycle after the result at the earliest.
// Configuration is taken at any time but must only be written while busy is low.
module page_run_bitmap_allocator
  import prba_pkg::*;
#(
  parameter int unsigned NUM_PAGES  = 1024,
  parameter int unsigned MAX_RUN    = 16,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  request_pages,
  output logic        done,
  output logic [31:0] block_address,
  output logic        granted,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  dp_cmd_t     cmd;
  dp_status_t  status;
  logic [31:0] addr_q;
  logic        grant_q;

  prba_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  prba_dp #(
    .NUM_PAGES  (NUM_PAGES),
    .MAX_RUN    (MAX_RUN),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .request_pages (request_pages),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .addr_q        (addr_q),
    .grant_q       (grant_q)
  );

  assign cfg_ready     = 1'b1;
  assign granted       = done & grant_q;
  assign block_address = done ? addr_q : '0;

endmodule

/* rtl/prba_checker.sv */
// Port-level checker for the page run bitmap allocator, bound to the top level.
module prba_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        granted,
  input logic [31:0] block_address
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_in_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe outside a transaction");

  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done)
    else $error("transaction did not end after its result");

  a_fell_after_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(done))
    else $error("transaction ended without a result");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    done && !granted |-> block_address == 32'd0)
    else $error("rejected transaction returned a nonzero address");

endmodule

bind page_run_bitmap_allocator prba_checker u_prba_checker (.*);

/* verif/tb_page_run_bitmap_allocator.sv */
// Self-checking testbench for the page run bitmap allocator: first-fit grants over random phases.
module tb_page_run_bitmap_allocator
  import prba_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_PAGES   = 1024;
  localparam int unsigned MAX_RUN     = 16;
  localparam int unsigned PAGE_SHIFT  = 12;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE      = 40;

  typedef enum logic [1:0] {STEP_REQUEST, STEP_WRITE, STEP_DRAIN} step_kind_t;

  typedef struct {
    step_kind_t  kind;
    logic [4:0]  pages;
    logic        reg_sel;
    logic [31:0] value;
    int unsigned hold;
  } alloc_step_t;

  typedef struct packed {
    logic [31:0] block_address;
    logic        granted;
  } grant_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [4:0]  request_pages = '0;
  logic        done;
  logic [31:0] block_address;
  logic        granted;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  page_run_bitmap_allocator #(
    .NUM_PAGES (NUM_PAGES),
    .MAX_RUN   (MAX_RUN),
    .PAGE_SHIFT(PAGE_SHIFT)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request_pages(request_pages),
    .done         (done),
    .block_address(block_address),
    .granted      (granted),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // allocator shadow state
  bit [NUM_PAGES-1:0] page_free = '1;
  logic [31:0]        shadow_base = '0;
  logic [10:0]        shadow_count = PAGE_COUNT_RST;

  alloc_step_t pending[$];
  grant_t      expected_grants[$];

  int unsigned issued = 0;
  int unsigned taken = 0;
  int unsigned grants_seen = 0;
  int unsigned refusals_seen = 0;
  int unsigned writes_done = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic grant_t first_fit_grant(input logic [4:0] len);
    grant_t      g;
    int unsigned lim;
    int unsigned s;
    int unsigned k;
    bit          fits;
    g = '0;
    lim = (shadow_count > NUM_PAGES) ? NUM_PAGES : shadow_count;
    if (len == 0 || len > MAX_RUN || len > lim) return g;
    for (s = 0; s + len <= lim; s++) begin
      fits = 1'b1;
      for (k = 0; k < len; k++) begin
        if (!page_free[s + k]) begin
          fits = 1'b0;
          break;
        end
      end
      if (fits) begin
        for (k = 0; k < len; k++) page_free[s + k] = 1'b0;
        g.block_address = shadow_base + (s << PAGE_SHIFT);
        g.granted = 1'b1;
        return g;
      end
    end
    return g;
  endfunction

  // mostly short runs, some long ones, a tenth rejected lengths
  function automatic logic [4:0] pick_pages();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 5'd0;
    if (r < 10) return 5'($urandom_range(MAX_RUN + 1, 31));
    if (r < 60) return 5'($urandom_range(1, 3));
    if (r < 90) return 5'($urandom_range(4, 8));
    return 5'($urandom_range(9, MAX_RUN));
  endfunction

  function automatic int unsigned pick_hold(input bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_request(input logic [4:0] pages, input int unsigned hold);
    alloc_step_t st;
    st.kind = STEP_REQUEST;
    st.pages = pages;
    st.reg_sel = REG_HEAP_BASE;
    st.value = '0;
    st.hold = hold;
    pending.push_back(st);
  endtask

  task automatic add_write(input logic sel, input logic [31:0] value);
    alloc_step_t st;
    st.kind = STEP_WRITE;
    st.pages = '0;
    st.reg_sel = sel;
    st.value = value;
    st.hold = 0;
    pending.push_back(st);
  endtask

  task automatic add_drain();
    alloc_step_t st;
    st.kind = STEP_DRAIN;
    st.pages = '0;
    st.reg_sel = REG_HEAP_BASE;
    st.value = '0;
    st.hold = 0;
    pending.push_back(st);
  endtask

  // driver
  always @(posedge clk) begin
    alloc_step_t head;
    grant_t      g;
    logic        nstart;
    logic        nvalid;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      nstart = start;
      nvalid = cfg_valid;
      if (start && !busy) begin
        head = pending.pop_front();
        g = first_fit_grant(head.pages);
        expected_grants.push_back(g);
        issued = issued + 1;
        if (g.granted) grants_seen = grants_seen + 1;
        else refusals_seen = refusals_seen + 1;
        nstart = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        head = pending.pop_front();
        if (head.reg_sel == REG_HEAP_BASE) shadow_base = head.value;
        else shadow_count = head.value[10:0];
        writes_done = writes_done + 1;
        nvalid = 1'b0;
      end
      if (!nstart && !nvalid && pending.size() > 0) begin
        head = pending[0];
        case (head.kind)
          STEP_REQUEST: begin
            if (head.hold > 0) begin
              pending[0].hold = head.hold - 1;
            end else begin
              nstart = 1'b1;
              request_pages <= head.pages;
            end
          end
          STEP_WRITE: begin
            if (issued == taken && !busy) begin
              nvalid = 1'b1;
              cfg_index <= head.reg_sel;
              cfg_data <= head.value;
            end
          end
          default: begin
            if (issued == taken) void'(pending.pop_front());
          end
        endcase
      end
      start <= nstart;
      cfg_valid <= nvalid;
    end
  end

  // monitor
  always @(posedge clk) begin
    grant_t want;
    if (!rst && done) begin
      if (expected_grants.size() == 0) begin
        $error("result with no transaction outstanding: block_address=%h granted=%b",
               block_address, granted);
        mismatches = mismatches + 1;
      end else begin
        want = expected_grants.pop_front();
        if (block_address !== want.block_address) begin
          $error("block_address: expected %h, actual %h", want.block_address, block_address);
          mismatches = mismatches + 1;
        end
        if (granted !== want.granted) begin
          $error("granted: expected %b, actual %b", want.granted, granted);
          mismatches = mismatches + 1;
        end
      end
      taken <= taken + 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("page_run_bitmap_allocator test failed");
      $finish;
    end
  end

  initial begin
    int unsigned ph;
    int unsigned n;
    int unsigned drain_at;
    bit          quiet;
    logic [31:0] base;
    logic [10:0] count;

    // zero page count: everything refused
    add_write(REG_HEAP_BASE, 32'h0);
    add_write(REG_PAGE_COUNT, 32'h0);
    add_request(5'd1, 0);
    add_request(5'd0, 0);
    add_request(5'd16, 0);
    // one page: grant, then no fit, then too long for the heap
    add_write(REG_PAGE_COUNT, 32'd1);
    add_request(5'd1, 0);
    add_request(5'd1, 2);
    add_request(5'd2, 0);
    // all-ones base, carry out of the top bit
    add_write(REG_HEAP_BASE, 32'hFFFF_FFFF);
    add_write(REG_PAGE_COUNT, 32'd20);
    add_request(5'd16, 0);
    add_request(5'd3, 0);
    add_request(5'd1, 0);
    // grant at page 20 wraps to address zero
    add_write(REG_HEAP_BASE, 32'hFFFE_C000);
    add_write(REG_PAGE_COUNT, 32'hFFFF_F828);
    add_request(5'd1, 0);
    add_request(5'd31, 1);
    add_request(5'd17, 0);
    add_request(5'd0, 0);
    // count lowered below free pages
    add_write(REG_PAGE_COUNT, 32'd30);
    add_request(5'd10, 0);
    add_request(5'd9, 0);
    // count above the heap size saturates
    add_write(REG_HEAP_BASE, 32'h1234_5000);
    add_write(REG_PAGE_COUNT, 32'd2047);
    add_request(5'd10, 0);
    add_request(5'd16, 0);
    add_request(5'd1, 3);
    add_request(5'd5, 0);

    for (ph = 0; ph < 11; ph++) begin
      case ($urandom_range(0, 3))
        0: base = 32'h0;
        1: base = 32'hFFFF_FFFF;
        2: base = $urandom();
        default: base = {20'($urandom_range(0, 32'hF_FFFF)), 12'h000};
      endcase
      if (ph == 4) count = 11'($urandom_range(0, 40));
      else if (ph == 9) count = 11'(NUM_PAGES);
      else if (ph == 10) count = 11'd2047;
      else if (ph == 7) count = 11'($urandom_range(0, 2047));
      else count = 11'((ph + 1) * 96 + $urandom_range(0, 40));
      n = $urandom_range(0, 2);
      if (n != 1) add_write(REG_HEAP_BASE, base);
      if (n != 0) add_write(REG_PAGE_COUNT, {21'($urandom()), count});
      quiet = (ph % 3 == 0);
      drain_at = (ph == 2 || ph == 6) ? $urandom_range(20, 90) : 200;
      for (n = 0; n < 110; n++) begin
        if (n == drain_at) add_drain();
        add_request(pick_pages(), pick_hold(quiet));
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    while (pending.size() > 0 || issued != taken) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("%0d requests over %0d register writes: %0d granted, %0d refused",
             issued, writes_done, grants_seen, refusals_seen);
    $display("%0d of %0d pages left free", $countones(page_free), NUM_PAGES);
    if (mismatches == 0 && expected_grants.size() == 0) begin
      $display("page_run_bitmap_allocator test passed");
    end else begin
      $display("page_run_bitmap_allocator test failed");
    end
    $finish;
  end

endmodule
